[design/caf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caf_pkg
// Shared types, constants and letter helpers of the frequency attack unit.
// ----------------------------------------------------------------------------
package caf_pkg;

  localparam int unsigned COUNT_BITS  = 16;
  localparam int unsigned NUM_LETTERS = 26;
  localparam int unsigned E_INDEX     = 4;
  localparam int unsigned TOP_BITS    = 16;

  localparam logic [7:0] UPPER_A = 8'h41;
  localparam logic [7:0] UPPER_Z = 8'h5a;
  localparam logic [7:0] LOWER_A = 8'h61;
  localparam logic [7:0] LOWER_Z = 8'h7a;

  localparam logic [4:0] LETTERS_5 = 5'(NUM_LETTERS);
  localparam logic [4:0] E_INDEX_5 = 5'(E_INDEX);

  typedef enum logic [1:0] {
    OP_COUNT   = 2'd0,
    OP_DECRYPT = 2'd1,
    OP_CLEAR   = 2'd2
  } caf_op_e;

  typedef struct packed {
    logic [4:0]            best_letter;
    logic [COUNT_BITS-1:0] best_count;
  } caf_hist_status_t;

  function automatic logic is_upper(input logic [7:0] ch);
    return (ch >= UPPER_A) && (ch <= UPPER_Z);
  endfunction

  function automatic logic is_lower(input logic [7:0] ch);
    return (ch >= LOWER_A) && (ch <= LOWER_Z);
  endfunction

  function automatic logic [4:0] letter_index(input logic [7:0] ch);
    logic [7:0] diff;
    diff = is_upper(ch) ? (ch - UPPER_A) : (ch - LOWER_A);
    return diff[4:0];
  endfunction

endpackage

[design/caf_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caf_if
// Valid/ready stream interfaces for input items and result items.
// ----------------------------------------------------------------------------
interface caf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] char_byte;

  modport source (output valid, output operation, output char_byte, input ready);
  modport sink   (input valid, input operation, input char_byte, output ready);
endinterface

interface caf_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  plain_byte;
  logic [4:0]  shift_used;
  logic [15:0] top_count;

  modport source (output valid, output plain_byte, output shift_used, output top_count,
                  input ready);
  modport sink   (input valid, input plain_byte, input shift_used, input top_count,
                  output ready);
endinterface

[design/caf_histogram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caf_histogram
// Saturating letter counters with a running argmax, lowest letter on ties.
// ----------------------------------------------------------------------------
module caf_histogram
  import caf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             count_en_i,
  input  logic             clear_i,
  input  logic [4:0]       index_i,
  output caf_hist_status_t status_o
);

  logic [COUNT_BITS-1:0] counts_q [NUM_LETTERS];
  logic [4:0]            best_letter_q;
  logic [COUNT_BITS-1:0] best_count_q;
  logic [COUNT_BITS-1:0] cur_count;
  logic [COUNT_BITS-1:0] next_count;
  logic                  new_best;

  assign cur_count  = counts_q[index_i];
  assign next_count = (&cur_count) ? cur_count : cur_count + 1'b1;
  assign new_best   = (next_count > best_count_q) ||
                      ((next_count == best_count_q) && (index_i < best_letter_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LETTERS; i++) counts_q[i] <= '0;
      best_letter_q <= '0;
      best_count_q  <= '0;
    end else if (clear_i) begin
      for (int i = 0; i < NUM_LETTERS; i++) counts_q[i] <= '0;
      best_letter_q <= '0;
      best_count_q  <= '0;
    end else if (count_en_i) begin
      counts_q[index_i] <= next_count;
      if (new_best) begin
        best_letter_q <= index_i;
        best_count_q  <= next_count;
      end
    end
  end

  assign status_o.best_letter = best_letter_q;
  assign status_o.best_count  = best_count_q;

endmodule

[design/caf_decrypt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caf_decrypt
// Derives the shift from the best letter and shifts a letter back, keeping case.
// ----------------------------------------------------------------------------
module caf_decrypt
  import caf_pkg::*;
(
  input  logic [7:0] char_byte_i,
  input  logic [4:0] best_letter_i,
  output logic [7:0] plain_byte_o,
  output logic [4:0] shift_o
);

  logic       upper;
  logic       lower;
  logic [4:0] idx;
  logic [4:0] shift;
  logic [4:0] plain_idx;
  logic [7:0] base;

  assign upper = is_upper(char_byte_i);
  assign lower = is_lower(char_byte_i);
  assign idx   = letter_index(char_byte_i);

  // best letter maps to 'e'
  assign shift = (best_letter_i >= E_INDEX_5) ? (best_letter_i - E_INDEX_5)
                                              : (best_letter_i + LETTERS_5 - E_INDEX_5);

  assign plain_idx = (idx >= shift) ? (idx - shift) : (idx + LETTERS_5 - shift);
  assign base      = upper ? UPPER_A : LOWER_A;

  assign plain_byte_o = (upper || lower) ? (base + {3'b000, plain_idx}) : char_byte_i;
  assign shift_o      = shift;

endmodule

[design/caesar_frequency_attack_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caesar_frequency_attack_unit
// Caesar cipher breaker by letter frequency analysis over a valid/ready stream.
// ----------------------------------------------------------------------------
// Each input transaction is registered, then handled by the histogram and
// decrypt logic; one transaction is accepted per cycle unless a registered
// decrypt transaction waits while the result register holds an untaken result.
// Count transactions add a case-folded letter to 26 saturating counters and
// produce no result; clear transactions empty the histogram; decrypt
// transactions produce one result transaction holding the byte shifted back by
// (best letter - 'e') mod 26, the shift (22 while the histogram is empty) and
// the top count saturated to 16 bits. The result passes from the input register
// to the result register; a following item sees the state left by the one
// before it.
module caesar_frequency_attack_unit
  import caf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  caf_in_if.sink    in_i,
  caf_out_if.source out_o
);

  logic       in_valid_q;
  logic [1:0] op_q;
  logic [7:0] char_q;

  logic       out_valid_q;
  logic [7:0] plain_q;
  logic [4:0] shift_q;
  logic [TOP_BITS-1:0] top_q;

  logic       out_free;
  logic       is_decrypt;
  logic       fire;
  logic       count_en;
  logic       clear;
  logic       load_out;

  caf_hist_status_t status;
  logic [7:0]  plain_byte;
  logic [4:0]  shift;
  logic [31:0] best_wide;
  logic [TOP_BITS-1:0] top_count;

  assign out_free   = !out_valid_q || out_o.ready;
  assign is_decrypt = (op_q == OP_DECRYPT);
  assign fire       = in_valid_q && (!is_decrypt || out_free);
  assign count_en   = fire && (op_q == OP_COUNT) && (is_upper(char_q) || is_lower(char_q));
  assign clear      = fire && (op_q == OP_CLEAR);
  assign load_out   = fire && is_decrypt;
  assign in_i.ready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      op_q   <= in_i.operation;
      char_q <= in_i.char_byte;
    end
  end

  caf_histogram u_histogram (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .count_en_i (count_en),
    .clear_i    (clear),
    .index_i    (letter_index(char_q)),
    .status_o   (status)
  );

  caf_decrypt u_decrypt (
    .char_byte_i   (char_q),
    .best_letter_i (status.best_letter),
    .plain_byte_o  (plain_byte),
    .shift_o       (shift)
  );

  assign best_wide = 32'(status.best_count);
  assign top_count = (best_wide > 32'h0000_ffff) ? '1 : best_wide[TOP_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      plain_q <= plain_byte;
      shift_q <= shift;
      top_q   <= top_count;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.plain_byte = plain_q;
  assign out_o.shift_used = shift_q;
  assign out_o.top_count  = top_q;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Caesar frequency attack unit. A directed table
// covers empty-histogram shifts, byte range edges, ties, the unused operation
// and clearing. Random letter streams with a hot letter and random decrypt
// bytes follow. A behavioral model of the histogram and running argmax
// predicts each decrypt result that is not pinned in the table, and a
// scoreboard compares the output stream field by field under random sender
// bursts, receiver stall patterns and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import caf_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 1200;

  typedef struct packed {
    logic [7:0]  plain;
    logic [4:0]  shift;
    logic [15:0] top;
  } plain_rec_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] ch;
    bit         pinned;
    plain_rec_t res;
  } stim_row_t;

  logic clk;
  logic rst_n;

  caf_in_if  in_bus ();
  caf_out_if out_bus ();

  caesar_frequency_attack_unit DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  // histogram model
  logic [COUNT_BITS-1:0] freq_tab [NUM_LETTERS];
  logic [4:0]            lead_letter;
  logic [COUNT_BITS-1:0] lead_count;

  plain_rec_t plain_q [$];
  int         fail_cnt;

  int         burst_left;
  int         gap_max;
  bit         hold_req;
  bit         pin_en;
  plain_rec_t pin_rec;

  stim_row_t dir_tab [25] = '{
    '{OP_DECRYPT, "a",   1'b1, '{"e",   5'd22, 16'd0}},
    '{OP_DECRYPT, "Z",   1'b1, '{"D",   5'd22, 16'd0}},
    '{OP_DECRYPT, 8'h00, 1'b1, '{8'h00, 5'd22, 16'd0}},
    '{OP_DECRYPT, 8'hff, 1'b1, '{8'hff, 5'd22, 16'd0}},
    '{OP_DECRYPT, 8'h40, 1'b1, '{8'h40, 5'd22, 16'd0}},
    '{OP_DECRYPT, 8'h5b, 1'b1, '{8'h5b, 5'd22, 16'd0}},
    '{OP_DECRYPT, 8'h7b, 1'b1, '{8'h7b, 5'd22, 16'd0}},
    '{OP_COUNT,   8'h80, 1'b0, '0},
    '{OP_COUNT,   8'h60, 1'b0, '0},
    '{OP_DECRYPT, "a",   1'b1, '{"e",   5'd22, 16'd0}},
    '{OP_COUNT,   "e",   1'b0, '0},
    '{OP_DECRYPT, "H",   1'b1, '{"H",   5'd0,  16'd1}},
    '{OP_COUNT,   "B",   1'b0, '0},
    '{OP_DECRYPT, "b",   1'b1, '{"e",   5'd23, 16'd1}},
    '{OP_UNUSED,  "e",   1'b0, '0},
    '{OP_COUNT,   "E",   1'b0, '0},
    '{OP_DECRYPT, "z",   1'b1, '{"z",   5'd0,  16'd2}},
    '{OP_CLEAR,   8'hff, 1'b0, '0},
    '{OP_DECRYPT, "A",   1'b1, '{"E",   5'd22, 16'd0}},
    '{OP_COUNT,   "Z",   1'b0, '0},
    '{OP_COUNT,   "z",   1'b0, '0},
    '{OP_DECRYPT, "Z",   1'b1, '{"E",   5'd21, 16'd2}},
    '{OP_UNUSED,  8'hff, 1'b0, '0},
    '{OP_COUNT,   "m",   1'b0, '0},
    '{OP_DECRYPT, 8'h7f, 1'b0, '0}
  };

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  task automatic hist_clear();
    for (int k = 0; k < NUM_LETTERS; k++) freq_tab[k] = '0;
    lead_letter = '0;
    lead_count  = '0;
  endtask

  task automatic crack_step(input logic [1:0] op, input logic [7:0] ch,
                            output bit emits, output plain_rec_t rec);
    logic                  up;
    logic                  lo;
    logic [4:0]            idx;
    logic [COUNT_BITS-1:0] cnt;
    int unsigned           shf;
    int unsigned           base;
    up    = (ch >= UPPER_A) && (ch <= UPPER_Z);
    lo    = (ch >= LOWER_A) && (ch <= LOWER_Z);
    emits = 1'b0;
    rec   = '0;
    case (op)
      OP_COUNT: begin
        if (up || lo) begin
          idx = up ? 5'(ch - UPPER_A) : 5'(ch - LOWER_A);
          cnt = freq_tab[idx];
          if (cnt != '1) cnt = cnt + 1'b1;
          freq_tab[idx] = cnt;
          if (cnt > lead_count || (cnt == lead_count && idx < lead_letter)) begin
            lead_letter = idx;
            lead_count  = cnt;
          end
        end
      end
      OP_CLEAR: begin
        hist_clear();
      end
      OP_DECRYPT: begin
        shf       = (lead_letter + NUM_LETTERS - E_INDEX) % NUM_LETTERS;
        rec.plain = ch;
        if (up || lo) begin
          base      = up ? UPPER_A : LOWER_A;
          rec.plain = 8'((ch - base + NUM_LETTERS - shf) % NUM_LETTERS + base);
        end
        rec.shift = 5'(shf);
        rec.top   = (32'(lead_count) > 32'hffff) ? 16'hffff : 16'(lead_count);
        emits     = 1'b1;
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin : accept_mon
    bit         emits;
    plain_rec_t rec;
    if (rst_n && in_bus.valid && in_bus.ready) begin
      crack_step(in_bus.operation, in_bus.char_byte, emits, rec);
      if (emits) begin
        if (pin_en) rec = pin_rec;
        plain_q.push_back(rec);
      end
    end
  end

  always @(posedge clk) begin : result_mon
    plain_rec_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (plain_q.size() == 0) begin
        fail_cnt++;
        $error("result transaction with none expected, plain_byte %h",
               out_bus.plain_byte);
      end else begin
        want = plain_q.pop_front();
        if (out_bus.plain_byte !== want.plain) begin
          fail_cnt++;
          $error("plain_byte: expected %h, actual %h", want.plain, out_bus.plain_byte);
        end
        if (out_bus.shift_used !== want.shift) begin
          fail_cnt++;
          $error("shift_used: expected %0d, actual %0d", want.shift, out_bus.shift_used);
        end
        if (out_bus.top_count !== want.top) begin
          fail_cnt++;
          $error("top_count: expected %0d, actual %0d", want.top, out_bus.top_count);
        end
      end
    end
  end

  // receiver: periodic stall patterns plus one long hold-off on request
  initial begin
    int hold_left;
    int phase_left;
    int period;
    int low_len;
    int tick;
    logic rdy;
    hold_left     = 0;
    phase_left    = 0;
    period        = 1;
    low_len       = 0;
    tick          = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        if (phase_left == 0) begin
          period     = $urandom_range(9, 1);
          low_len    = $urandom_range(period - 1, 0);
          phase_left = $urandom_range(200, 20);
        end
        rdy = ((tick % period) >= low_len);
        tick++;
        phase_left--;
      end
      out_bus.ready <= rdy;
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [7:0] ch,
                           input bit pin, input plain_rec_t pin_val);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(gap_max, 0);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(32, 1);
    end
    in_bus.valid     <= 1'b1;
    in_bus.operation <= op;
    in_bus.char_byte <= ch;
    pin_en  = pin;
    pin_rec = pin_val;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
    burst_left--;
  endtask

  function automatic logic [7:0] rand_letter(input int unsigned idx);
    return 8'(($urandom_range(1, 0) ? UPPER_A : LOWER_A) + idx);
  endfunction

  initial begin
    int unsigned hot;
    int unsigned pick;
    logic [1:0]  op;
    logic [7:0]  ch;
    in_bus.valid     = 1'b0;
    in_bus.operation = OP_COUNT;
    in_bus.char_byte = 8'h00;
    fail_cnt   = 0;
    burst_left = 0;
    gap_max    = 4;
    hold_req   = 1'b0;
    pin_en     = 1'b0;
    pin_rec    = '0;
    hot        = 0;
    hist_clear();
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[i]) send_item(dir_tab[i].op, dir_tab[i].ch, dir_tab[i].pinned,
                                   dir_tab[i].res);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 150 == 0) begin
        hot     = $urandom_range(NUM_LETTERS - 1, 0);
        gap_max = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
      end
      if (i == 400) hold_req = 1'b1;
      pick = $urandom_range(99, 0);
      ch   = 8'($urandom_range(255, 0));
      if (i >= 400 && i < 440) begin
        op = OP_DECRYPT;
      end else if (pick < 50) begin
        op = OP_COUNT;
        ch = rand_letter(($urandom_range(9, 0) < 7) ? hot
                                                     : $urandom_range(NUM_LETTERS - 1, 0));
      end else if (pick < 55) begin
        op = OP_COUNT;
      end else if (pick < 92) begin
        op = OP_DECRYPT;
        if (pick < 80) ch = rand_letter($urandom_range(NUM_LETTERS - 1, 0));
      end else if (pick < 96) begin
        op = OP_CLEAR;
      end else begin
        op = OP_UNUSED;
      end
      send_item(op, ch, 1'b0, '0);
    end
    in_bus.valid <= 1'b0;

    while (plain_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_cnt == 0 && plain_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
